// ----- src/kmp_pkg.sv -----
`timescale 1ns / 1ps
package kmp_pkg;

   localparam int PRICE_W  = 14;
   localparam int PROFIT_W = 20;
   localparam int CSR_W    = 7;
   localparam int SCORE_W  = 24;

   typedef logic signed [SCORE_W-1:0] score_type;

   // empty-slot marker, kept negative so it never wins a max
   localparam score_type NEG_SENTINEL = -score_type'(24'h3f3f3f);

   localparam logic [CSR_W-1:0] CSR_RESET_K = CSR_W'(2);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_REDUCE,
      ST_RESULT
   } kmp_state_type;

   typedef struct packed {
      logic load;
      logic update;
      logic shift;
   } cell_ctl_type;

endpackage

// ----- src/kmp_if.sv -----
`timescale 1ns / 1ps
interface kmp_req_if;
   import kmp_pkg::*;
   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] price;
   logic               last_day;
   modport source (output valid, output price, output last_day, input ready);
   modport sink   (input valid, input price, input last_day, output ready);
endinterface

interface kmp_rsp_if;
   import kmp_pkg::*;
   logic                valid;
   logic                ready;
   logic [PROFIT_W-1:0] best_profit;
   modport source (output valid, output best_profit, input ready);
   modport sink   (input valid, input best_profit, output ready);
endinterface

interface kmp_csr_if;
   import kmp_pkg::*;
   logic             valid;
   logic             ready;
   logic [CSR_W-1:0] max_transactions;
   modport source (output valid, output max_transactions, input ready);
   modport sink   (input valid, input max_transactions, output ready);
endinterface

// ----- src/kmp_cell.sv -----
`timescale 1ns / 1ps
module kmp_cell (
   input  logic                         clock,
   input  kmp_pkg::cell_ctl_type        ctl,
   input  logic [kmp_pkg::PRICE_W-1:0]  price,
   input  kmp_pkg::score_type           hold_left,
   input  kmp_pkg::score_type           free_right,
   input  kmp_pkg::score_type           load_hold,
   input  kmp_pkg::score_type           load_free,
   output kmp_pkg::score_type           hold,
   output kmp_pkg::score_type           free
);
   import kmp_pkg::*;

   score_type hold_ff, hold_in;
   score_type free_ff, free_in;
   score_type p_ext;
   score_type sell_val;
   score_type buy_val;

   assign p_ext    = score_type'({{(SCORE_W-PRICE_W){1'b0}}, price});
   assign buy_val  = free_ff - p_ext;
   assign sell_val = hold_left + p_ext;

   always_comb begin
      hold_in = hold_ff;
      free_in = free_ff;
      if (ctl.load) begin
         hold_in = load_hold;
         free_in = load_free;
      end else if (ctl.update) begin
         hold_in = (buy_val > hold_ff) ? buy_val : hold_ff;
         free_in = (sell_val > free_ff) ? sell_val : free_ff;
      end else if (ctl.shift) begin
         // free scores march toward cell 0 for the final max
         free_in = free_right;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      free_ff <= free_in;
   end

   assign hold = hold_ff;
   assign free = free_ff;

endmodule

// ----- src/kmp_ctrl.sv -----
`timescale 1ns / 1ps
module kmp_ctrl #(
   parameter int MAX_TRANS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   kmp_req_if.sink               req,
   kmp_rsp_if.source             rsp,
   kmp_csr_if.sink               csr,
   input  kmp_pkg::score_type    head_free,
   output kmp_pkg::cell_ctl_type ctl
);
   import kmp_pkg::*;

   localparam int CNT_W = $clog2(MAX_TRANS + 1);

   kmp_state_type    state_ff, state_in;
   logic             started_ff, started_in;
   logic [CSR_W-1:0] max_trans_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] kcap_ff, kcap_in;
   logic [CNT_W-1:0] kcap;
   score_type        best_ff, best_in;

   assign csr.ready = 1'b1;
   assign kcap = (max_trans_ff > CSR_W'(MAX_TRANS)) ? CNT_W'(MAX_TRANS)
                                                    : max_trans_ff[CNT_W-1:0];
   assign rsp.best_profit = best_ff[PROFIT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         max_trans_ff <= CSR_RESET_K;
      end else if (csr.valid && csr.ready) begin
         max_trans_ff <= csr.max_transactions;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      kcap_ff <= kcap_in;
      best_ff <= best_in;
   end

   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      cnt_in     = cnt_ff;
      kcap_in    = kcap_ff;
      best_in    = best_ff;
      ctl        = '0;
      req.ready  = 1'b0;
      rsp.valid  = 1'b0;
      case (state_ff)
         ST_RUN: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (started_ff) begin
                  ctl.update = 1'b1;
               end else begin
                  ctl.load = 1'b1;
               end
               started_in = 1'b1;
               if (req.last_day) begin
                  started_in = 1'b0;
                  state_in   = ST_REDUCE;
                  cnt_in     = '0;
                  kcap_in    = kcap;
                  best_in    = '0;
               end
            end
         end
         ST_REDUCE: begin
            // one cell's free score reaches the head per cycle
            ctl.shift = 1'b1;
            if (head_free > best_ff) begin
               best_in = head_free;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == kcap_ff) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   a_ctl_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.load, ctl.update, ctl.shift}))
      else $error("cell controls overlap");

   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.last_day) |=> !req.ready)
      else $error("input taken right after last price");

   a_best_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (best_ff >= 0))
      else $error("negative profit offered");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE) |-> (cnt_ff <= kcap_ff))
      else $error("reduction count past k");

   a_load_first: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.last_day) |=> !started_ff)
      else $error("sequence still open after last price");

endmodule

// ----- src/k_transaction_max_profit.sv -----
`timescale 1ns / 1ps
// Best profit from at most k buy-sell transactions over a price stream. Each
// price transfer updates a chain of MAX_TRANS+1 cells (one per completed
// transaction count) at once, so ordinary prices go at one per cycle. A price
// marked last_day is followed by a reduction in which the free scores of cells
// 0 to min(k, MAX_TRANS) shift down the chain into a running-max register;
// the result then waits in that register until the rsp transfer, and no new
// price is taken from the last price until then. k is max_transactions
// (reset 2), saturated to MAX_TRANS; the value held at the last price counts.
module k_transaction_max_profit #(
   parameter int MAX_TRANS = 16
) (
   input logic       clock,
   input logic       reset,
   kmp_req_if.sink   req_ch,
   kmp_rsp_if.source rsp_ch,
   kmp_csr_if.sink   csr_ch
);
   import kmp_pkg::*;

   localparam int NCELL = MAX_TRANS + 1;

   cell_ctl_type ctl;
   score_type    hold_v [NCELL];
   score_type    free_v [NCELL];

   kmp_ctrl #(.MAX_TRANS(MAX_TRANS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr       (csr_ch),
      .head_free (free_v[0]),
      .ctl       (ctl)
   );

   for (genvar j = 0; j < NCELL; j++) begin : g_cell
      score_type hold_left;
      score_type free_right;
      score_type load_hold;
      score_type load_free;

      if (j == 0) begin : g_head
         assign hold_left = NEG_SENTINEL;
         assign load_hold = -score_type'({{(SCORE_W-PRICE_W){1'b0}}, req_ch.price});
         assign load_free = '0;
      end else begin : g_body
         assign hold_left = hold_v[j-1];
         assign load_hold = NEG_SENTINEL;
         assign load_free = NEG_SENTINEL;
      end

      if (j == NCELL - 1) begin : g_tail
         assign free_right = NEG_SENTINEL;
      end else begin : g_mid
         assign free_right = free_v[j+1];
      end

      kmp_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .price      (req_ch.price),
         .hold_left  (hold_left),
         .free_right (free_right),
         .load_hold  (load_hold),
         .load_free  (load_free),
         .hold       (hold_v[j]),
         .free       (free_v[j])
      );
   end

endmodule
